// ===== hdl/nearest_neighbour_scale_address_gen_core_defines.svh =====
// Assertion macros shared by the address generator RTL.
`ifndef NEAREST_NEIGHBOUR_SCALE_ADDRESS_GEN_CORE_DEFINES_SVH
`define NEAREST_NEIGHBOUR_SCALE_ADDRESS_GEN_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define NNSA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("address generator check failed");

// Check that cons holds in the cycle after ante.
`define NNSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("address generator check failed");

`endif

// ===== hdl/nnsa_pkg.sv =====
// Shared constants and types of the nearest-neighbor scaler address generator.
`timescale 1ns / 1ps

package nnsa_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 10;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_SRC_WIN_X  = 3'd4,
        REG_SRC_WIN_Y  = 3'd5,
        REG_DST_WIN_X  = 3'd6,
        REG_DST_WIN_Y  = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_EMIT
    } state_t;

endpackage

// ===== hdl/nnsa_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module nnsa_div #(
    parameter int COORD_BITS = nnsa_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = nnsa_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [COORD_BITS+FRAC_BITS-1:0] dividend,
    input  logic [COORD_BITS-1:0]           divisor,
    output logic                            done,
    output logic [COORD_BITS+FRAC_BITS-1:0] quotient
);

    localparam int ACC_BITS = COORD_BITS + FRAC_BITS;
    localparam int CNT_BITS = $clog2(ACC_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [ACC_BITS-1:0]   quo_reg, quo_next;
    logic [COORD_BITS-1:0] dvs_reg, dvs_next;

    logic [COORD_BITS:0]   shifted;
    logic [COORD_BITS:0]   trial;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[ACC_BITS-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
            quo_next = {quo_reg[ACC_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(ACC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/nearest_neighbour_scale_address_gen_core.sv =====
// Nearest-neighbor scaler address generator: top level.
// A command item with restart low yields the next output pixel in raster order; its result
// is registered in the cycle after acceptance, and such items are taken one per cycle while
// the result register drains. A command with restart high clears the position and runs two
// divisions, (src_width << FRAC_BITS) / dst_width and then the same for the height, on one
// shared bit-serial divider of COORD_BITS+FRAC_BITS steps each; pixel 0,0 is registered
// from ST_EMIT once both are done and the result register is free, and no command is
// accepted meanwhile. A zero output width or height gives no result and no division. Write
// the registers only while no command is in progress; a write takes effect at once.
`timescale 1ns / 1ps
`include "nearest_neighbour_scale_address_gen_core_defines.svh"

module nearest_neighbour_scale_address_gen_core #(
    parameter int COORD_BITS = nnsa_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = nnsa_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [nnsa_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]             cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic                              restart,
    output logic                              pix_valid,
    input  logic                              pix_stall,
    output logic [COORD_BITS:0]               src_col,
    output logic [COORD_BITS:0]               src_row,
    output logic [COORD_BITS:0]               chroma_col,
    output logic [COORD_BITS-1:0]             chroma_row,
    output logic [COORD_BITS:0]               dst_col,
    output logic [COORD_BITS:0]               dst_row,
    output logic                              src_col_odd,
    output logic                              dst_col_odd,
    output logic                              row_end,
    output logic                              frame_end
);

    localparam int ACC_BITS = COORD_BITS + FRAC_BITS;

    logic [COORD_BITS-1:0] sw_reg, sh_reg, dw_reg, dh_reg;
    logic [COORD_BITS-1:0] sx_reg, sy_reg, dx_reg, dy_reg;

    nnsa_pkg::state_t      state_reg, state_next;

    logic [ACC_BITS-1:0]   step_x_reg, step_y_reg;
    logic [ACC_BITS-1:0]   acc_x_reg, acc_y_reg;
    logic [COORD_BITS-1:0] out_col_reg, out_row_reg;

    logic                  pix_valid_reg;
    logic [COORD_BITS:0]   src_col_reg, src_row_reg, chroma_col_reg;
    logic [COORD_BITS-1:0] chroma_row_reg;
    logic [COORD_BITS:0]   dst_col_reg, dst_row_reg;
    logic                  src_col_odd_reg, dst_col_odd_reg, row_end_reg, frame_end_reg;

    logic                  cmd_accept;
    logic                  slot_free;
    logic                  dims_zero;
    logic                  in_div;
    logic                  emit;
    logic                  clear_pos;
    logic                  clear_step;
    logic                  div_start;
    logic                  div_done;
    logic [ACC_BITS-1:0]   div_dividend;
    logic [COORD_BITS-1:0] div_divisor;
    logic [ACC_BITS-1:0]   div_quotient;

    logic [COORD_BITS-1:0] in_x, in_y;
    logic [COORD_BITS:0]   px_src_col, px_src_row, px_chroma_col, px_dst_col, px_dst_row;
    logic                  px_row_end, px_frame_end;

    assign slot_free  = !pix_valid_reg || !pix_stall;
    assign cmd_stall  = (state_reg != nnsa_pkg::ST_IDLE) || !slot_free;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign dims_zero  = (dw_reg == '0) || (dh_reg == '0);
    assign in_div     = (state_reg == nnsa_pkg::ST_DIV_X) || (state_reg == nnsa_pkg::ST_DIV_Y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= '0;
            sh_reg <= '0;
            dw_reg <= '0;
            dh_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            dx_reg <= '0;
            dy_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (nnsa_pkg::reg_idx_t'(cfg_index))
                nnsa_pkg::REG_SRC_WIDTH:  sw_reg <= cfg_data;
                nnsa_pkg::REG_SRC_HEIGHT: sh_reg <= cfg_data;
                nnsa_pkg::REG_DST_WIDTH:  dw_reg <= cfg_data;
                nnsa_pkg::REG_DST_HEIGHT: dh_reg <= cfg_data;
                nnsa_pkg::REG_SRC_WIN_X:  sx_reg <= cfg_data;
                nnsa_pkg::REG_SRC_WIN_Y:  sy_reg <= cfg_data;
                nnsa_pkg::REG_DST_WIN_X:  dx_reg <= cfg_data;
                nnsa_pkg::REG_DST_WIN_Y:  dy_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nnsa_pkg::ST_IDLE:
                if (cmd_accept && restart && !dims_zero)
                    state_next = nnsa_pkg::ST_DIV_X;
            nnsa_pkg::ST_DIV_X:
                if (div_done)
                    state_next = nnsa_pkg::ST_DIV_Y;
            nnsa_pkg::ST_DIV_Y:
                if (div_done)
                    state_next = nnsa_pkg::ST_EMIT;
            nnsa_pkg::ST_EMIT:
                if (slot_free)
                    state_next = nnsa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        emit         = 1'b0;
        clear_pos    = 1'b0;
        clear_step   = 1'b0;
        div_start    = 1'b0;
        div_dividend = {sw_reg, {FRAC_BITS{1'b0}}};
        div_divisor  = dw_reg;
        unique case (state_reg)
            nnsa_pkg::ST_IDLE:
            begin
                emit       = cmd_accept && !restart && !dims_zero;
                clear_pos  = cmd_accept && restart;
                clear_step = cmd_accept && restart && dims_zero;
                div_start  = cmd_accept && restart && !dims_zero;
            end
            nnsa_pkg::ST_DIV_X:
            begin
                div_start    = div_done;
                div_dividend = {sh_reg, {FRAC_BITS{1'b0}}};
                div_divisor  = dh_reg;
            end
            nnsa_pkg::ST_DIV_Y:
            begin
                div_dividend = {sh_reg, {FRAC_BITS{1'b0}}};
                div_divisor  = dh_reg;
            end
            nnsa_pkg::ST_EMIT:
                emit = slot_free;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nnsa_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    nnsa_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign in_x          = acc_x_reg[ACC_BITS-1:FRAC_BITS];
    assign in_y          = acc_y_reg[ACC_BITS-1:FRAC_BITS];
    assign px_src_col    = {1'b0, sx_reg} + {1'b0, in_x};
    assign px_src_row    = {1'b0, sy_reg} + {1'b0, in_y};
    assign px_chroma_col = {1'b0, sx_reg} + {1'b0, in_x[COORD_BITS-1:1], 1'b0};
    assign px_dst_col    = {1'b0, dx_reg} + {1'b0, out_col_reg};
    assign px_dst_row    = {1'b0, dy_reg} + {1'b0, out_row_reg};
    assign px_row_end    = ({1'b0, out_col_reg} + 1'b1) >= {1'b0, dw_reg};
    assign px_frame_end  = px_row_end && (({1'b0, out_row_reg} + 1'b1) >= {1'b0, dh_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg  <= '0;
            step_y_reg  <= '0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            if (clear_step)
            begin
                step_x_reg <= '0;
                step_y_reg <= '0;
            end
            else if (div_done && state_reg == nnsa_pkg::ST_DIV_X)
                step_x_reg <= div_quotient;
            else if (div_done && state_reg == nnsa_pkg::ST_DIV_Y)
                step_y_reg <= div_quotient;

            if (clear_pos)
            begin
                acc_x_reg   <= '0;
                acc_y_reg   <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else if (emit)
            begin
                if (px_row_end)
                begin
                    out_col_reg <= '0;
                    acc_x_reg   <= '0;
                    if (px_frame_end)
                    begin
                        out_row_reg <= '0;
                        acc_y_reg   <= '0;
                    end
                    else
                    begin
                        out_row_reg <= out_row_reg + 1'b1;
                        acc_y_reg   <= acc_y_reg + step_y_reg;
                    end
                end
                else
                begin
                    out_col_reg <= out_col_reg + 1'b1;
                    acc_x_reg   <= acc_x_reg + step_x_reg;
                end
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else if (emit)
            pix_valid_reg <= 1'b1;
        else if (!pix_stall)
            pix_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            src_col_reg     <= px_src_col;
            src_row_reg     <= px_src_row;
            chroma_col_reg  <= px_chroma_col;
            chroma_row_reg  <= px_src_row[COORD_BITS:1];
            dst_col_reg     <= px_dst_col;
            dst_row_reg     <= px_dst_row;
            src_col_odd_reg <= in_x[0];
            dst_col_odd_reg <= out_col_reg[0];
            row_end_reg     <= px_row_end;
            frame_end_reg   <= px_frame_end;
        end
    end

    assign pix_valid   = pix_valid_reg;
    assign src_col     = src_col_reg;
    assign src_row     = src_row_reg;
    assign chroma_col  = chroma_col_reg;
    assign chroma_row  = chroma_row_reg;
    assign dst_col     = dst_col_reg;
    assign dst_row     = dst_row_reg;
    assign src_col_odd = src_col_odd_reg;
    assign dst_col_odd = dst_col_odd_reg;
    assign row_end     = row_end_reg;
    assign frame_end   = frame_end_reg;

    `NNSA_ASSERT_SAME(a_div_done_in_div, div_done, in_div)
    `NNSA_ASSERT_NEXT(a_restart_starts_div, clear_pos && !dims_zero, state_reg == nnsa_pkg::ST_DIV_X)
    `NNSA_ASSERT_NEXT(a_emit_loads_result, emit, pix_valid_reg)
    `NNSA_ASSERT_SAME(a_frame_end_row_end, pix_valid_reg && frame_end_reg, row_end_reg)

endmodule

// ===== dv/nearest_neighbour_scale_address_gen_core_tb.sv =====
// Self-checking testbench for the nearest-neighbor scaler address generator core.
`timescale 1ns / 1ps

module nearest_neighbour_scale_address_gen_core_tb;

    localparam int CB           = nnsa_pkg::COORD_BITS_DEF;
    localparam int FB           = nnsa_pkg::FRAC_BITS_DEF;
    localparam int AB           = CB + FB;
    localparam int DRAIN_CYCLES = 2 * AB + 3 + 16;
    localparam int HOLD_LEN     = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DIR_ROWS     = 48;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic [CB:0]   src_col;
        logic [CB:0]   src_row;
        logic [CB:0]   chroma_col;
        logic [CB-1:0] chroma_row;
        logic [CB:0]   dst_col;
        logic [CB:0]   dst_row;
        logic          src_col_odd;
        logic          dst_col_odd;
        logic          row_end;
        logic          frame_end;
    } pix_t;

    typedef struct packed {
        bit                 is_cfg;
        nnsa_pkg::reg_idx_t idx;
        logic [CB-1:0]      val;
        bit                 rs;
        bit                 typed;
        pix_t               want;
    } dir_row_t;

    localparam pix_t CORNER_PIX = '{13'd4095, 13'd4095, 13'd4095, 12'd2047, 13'd4095,
                                    13'd4095, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam pix_t CORNER_LAST = '{13'd4095, 13'd4095, 13'd4095, 12'd2047, 13'd4095,
                                     13'd4095, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam pix_t ORIGIN_PIX = '0;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [nnsa_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CB-1:0] cfg_data = '0;
    logic          cmd_valid = 1'b0;
    logic          cmd_stall;
    logic          restart = 1'b0;
    logic          pix_valid;
    logic          pix_stall = 1'b1;
    logic [CB:0]   src_col;
    logic [CB:0]   src_row;
    logic [CB:0]   chroma_col;
    logic [CB-1:0] chroma_row;
    logic [CB:0]   dst_col;
    logic [CB:0]   dst_row;
    logic          src_col_odd;
    logic          dst_col_odd;
    logic          row_end;
    logic          frame_end;

    nearest_neighbour_scale_address_gen_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .restart     (restart),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .src_col     (src_col),
        .src_row     (src_row),
        .chroma_col  (chroma_col),
        .chroma_row  (chroma_row),
        .dst_col     (dst_col),
        .dst_row     (dst_row),
        .src_col_odd (src_col_odd),
        .dst_col_odd (dst_col_odd),
        .row_end     (row_end),
        .frame_end   (frame_end)
    );

    // scaler state mirror
    logic [CB-1:0] cfg_q [8];
    logic [AB-1:0] step_x, step_y, acc_x, acc_y;
    logic [CB-1:0] out_col, out_row;

    pix_t     pending_pixels [$];
    dir_row_t dir_tab [DIR_ROWS];

    int errors = 0;
    int items_done = 0;
    int restarts_done = 0;
    int pixels_seen = 0;
    int rows_seen = 0;
    int frames_seen = 0;
    int send_idle_pct = 36;
    int recv_idle_pct = 74;
    int stall_cycles = 0;
    int hold_cnt = 0;
    bit hold_go = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit next_pixel(input bit rs, output pix_t p);
        logic [CB-1:0] dw, dh, sx, sy;
        logic [CB-1:0] col_s, row_s;
        logic [AB-1:0] num;
        logic [CB:0]   srow;
        bit            rend, fend;
        dw = cfg_q[nnsa_pkg::REG_DST_WIDTH];
        dh = cfg_q[nnsa_pkg::REG_DST_HEIGHT];
        sx = cfg_q[nnsa_pkg::REG_SRC_WIN_X];
        sy = cfg_q[nnsa_pkg::REG_SRC_WIN_Y];
        p = '0;
        if (rs)
        begin
            acc_x = '0;
            acc_y = '0;
            out_col = '0;
            out_row = '0;
            if (dw == 0 || dh == 0)
            begin
                step_x = '0;
                step_y = '0;
                return 1'b0;
            end
            num = {cfg_q[nnsa_pkg::REG_SRC_WIDTH], {FB{1'b0}}};
            step_x = num / {{FB{1'b0}}, dw};
            num = {cfg_q[nnsa_pkg::REG_SRC_HEIGHT], {FB{1'b0}}};
            step_y = num / {{FB{1'b0}}, dh};
        end
        else if (dw == 0 || dh == 0)
        begin
            return 1'b0;
        end
        col_s = acc_x[AB-1:FB];
        row_s = acc_y[AB-1:FB];
        srow = {1'b0, sy} + {1'b0, row_s};
        rend = ({1'b0, out_col} + 1'b1) >= {1'b0, dw};
        fend = rend && (({1'b0, out_row} + 1'b1) >= {1'b0, dh});
        p.src_col     = {1'b0, sx} + {1'b0, col_s};
        p.src_row     = srow;
        p.chroma_col  = {1'b0, sx} + {1'b0, col_s[CB-1:1], 1'b0};
        p.chroma_row  = srow[CB:1];
        p.dst_col     = {1'b0, cfg_q[nnsa_pkg::REG_DST_WIN_X]} + {1'b0, out_col};
        p.dst_row     = {1'b0, cfg_q[nnsa_pkg::REG_DST_WIN_Y]} + {1'b0, out_row};
        p.src_col_odd = col_s[0];
        p.dst_col_odd = out_col[0];
        p.row_end     = rend;
        p.frame_end   = fend;
        if (rend)
        begin
            out_col = '0;
            acc_x = '0;
            if (fend)
            begin
                out_row = '0;
                acc_y = '0;
            end
            else
            begin
                out_row = out_row + 1'b1;
                acc_y = acc_y + step_y;
            end
        end
        else
        begin
            out_col = out_col + 1'b1;
            acc_x = acc_x + step_x;
        end
        return 1'b1;
    endfunction

    function automatic dir_row_t cfg_row(input nnsa_pkg::reg_idx_t i, input int v);
        dir_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = i;
        r.val = v[CB-1:0];
        return r;
    endfunction

    function automatic dir_row_t item_row(input bit rs);
        dir_row_t r;
        r = '0;
        r.rs = rs;
        return r;
    endfunction

    function automatic dir_row_t typed_row(input bit rs, input pix_t w);
        dir_row_t r;
        r = '0;
        r.rs = rs;
        r.typed = 1'b1;
        r.want = w;
        return r;
    endfunction

    function automatic logic [CB-1:0] pick_value(input nnsa_pkg::reg_idx_t i);
        int r;
        r = $urandom_range(99);
        unique case (i)
            nnsa_pkg::REG_SRC_WIDTH, nnsa_pkg::REG_SRC_HEIGHT:
                if (r < 10) return '0;
                else if (r < 25) return {CB{1'b1}};
                else return CB'($urandom_range(0, 4095));
            nnsa_pkg::REG_DST_WIDTH, nnsa_pkg::REG_DST_HEIGHT:
                if (r < 4) return '0;
                else if (r < 12) return {CB{1'b1}};
                else if (r < 25) return CB'(1);
                else return CB'($urandom_range(2, 10));
            default:
                if (r < 20) return '0;
                else if (r < 40) return {CB{1'b1}};
                else return CB'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp);
        if (errors < MAX_PRINTS)
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
        errors++;
    endtask

    task automatic write_reg(input nnsa_pkg::reg_idx_t i, input logic [CB-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= i;
        cfg_data <= v;
        @(posedge clk);
        cfg_q[i] = v;
    endtask

    // drop valid, drain every pending pixel, then let a restart division finish
    task automatic quiesce();
        cmd_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic issue_tick(input bit rs, input bit typed, input pix_t want);
        bit   taken;
        pix_t p;
        cfg_wr_en <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        restart <= rs;
        do
        begin
            @(negedge clk);
            taken = !cmd_stall;
            if (taken)
            begin
                if (cfg_q[nnsa_pkg::REG_DST_WIDTH] != 0 && cfg_q[nnsa_pkg::REG_DST_HEIGHT] != 0)
                    items_done++;
                if (rs)
                    restarts_done++;
                if (next_pixel(rs, p))
                    pending_pixels.push_back(typed ? want : p);
            end
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic run_random_phase();
        int i;
        int n;
        bit dims_ok;
        quiesce();
        for (i = 0; i < 8; i++)
            if ($urandom_range(1))
                write_reg(nnsa_pkg::reg_idx_t'(i), pick_value(nnsa_pkg::reg_idx_t'(i)));
        dims_ok = cfg_q[nnsa_pkg::REG_DST_WIDTH] != 0 && cfg_q[nnsa_pkg::REG_DST_HEIGHT] != 0;
        n = dims_ok ? $urandom_range(8, 60) : 4;
        if (items_done >= 2 * RANDOM_ITEMS / 3)
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            if (dims_ok)
                hold_go = 1'b1;
        end
        else if (items_done >= RANDOM_ITEMS / 3)
        begin
            send_idle_pct = 74;
            recv_idle_pct = 36;
        end
        // keep the old steps now and then to cover a mid-frame register change
        if ($urandom_range(3) != 0)
            issue_tick(1'b1, 1'b0, '0);
        for (i = 0; i < n; i++)
            issue_tick($urandom_range(29) == 0, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (hold_go && hold_cnt < HOLD_LEN)
        begin
            pix_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end
        else
        begin
            pix_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(negedge clk)
    begin
        pix_t got;
        pix_t exp;
        if (rst_n && pix_valid && !pix_stall)
        begin
            got = '{src_col, src_row, chroma_col, chroma_row, dst_col, dst_row,
                    src_col_odd, dst_col_odd, row_end, frame_end};
            pixels_seen++;
            if (row_end)
                rows_seen++;
            if (frame_end)
                frames_seen++;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("unexpected pixel dst_col", got.dst_col, 0);
            end
            else
            begin
                exp = pending_pixels.pop_front();
                if (got.src_col !== exp.src_col)
                    report_mismatch("src_col", got.src_col, exp.src_col);
                if (got.src_row !== exp.src_row)
                    report_mismatch("src_row", got.src_row, exp.src_row);
                if (got.chroma_col !== exp.chroma_col)
                    report_mismatch("chroma_col", got.chroma_col, exp.chroma_col);
                if (got.chroma_row !== exp.chroma_row)
                    report_mismatch("chroma_row", got.chroma_row, exp.chroma_row);
                if (got.dst_col !== exp.dst_col)
                    report_mismatch("dst_col", got.dst_col, exp.dst_col);
                if (got.dst_row !== exp.dst_row)
                    report_mismatch("dst_row", got.dst_row, exp.dst_row);
                if (got.src_col_odd !== exp.src_col_odd)
                    report_mismatch("src_col_odd", got.src_col_odd, exp.src_col_odd);
                if (got.dst_col_odd !== exp.dst_col_odd)
                    report_mismatch("dst_col_odd", got.dst_col_odd, exp.dst_col_odd);
                if (got.row_end !== exp.row_end)
                    report_mismatch("row_end", got.row_end, exp.row_end);
                if (got.frame_end !== exp.frame_end)
                    report_mismatch("frame_end", got.frame_end, exp.frame_end);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (pix_valid && !pix_stall) || cfg_wr_en)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: %0d cycles without progress, %0d pixels pending",
                         stall_cycles, pending_pixels.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        for (k = 0; k < 8; k++)
            cfg_q[k] = '0;
        step_x = '0;
        step_y = '0;
        acc_x = '0;
        acc_y = '0;
        out_col = '0;
        out_row = '0;
        dir_tab = '{
            item_row(1'b0),
            item_row(1'b1),
            cfg_row(nnsa_pkg::REG_SRC_WIDTH, 4095),
            cfg_row(nnsa_pkg::REG_SRC_HEIGHT, 4095),
            cfg_row(nnsa_pkg::REG_DST_WIDTH, 3),
            cfg_row(nnsa_pkg::REG_DST_HEIGHT, 2),
            cfg_row(nnsa_pkg::REG_SRC_WIN_X, 4095),
            cfg_row(nnsa_pkg::REG_SRC_WIN_Y, 4095),
            cfg_row(nnsa_pkg::REG_DST_WIN_X, 4095),
            cfg_row(nnsa_pkg::REG_DST_WIN_Y, 4095),
            typed_row(1'b0, CORNER_PIX),
            item_row(1'b0),
            item_row(1'b0),
            item_row(1'b0),
            item_row(1'b0),
            item_row(1'b0),
            typed_row(1'b0, CORNER_PIX),
            typed_row(1'b1, CORNER_PIX),
            item_row(1'b0),
            cfg_row(nnsa_pkg::REG_DST_WIDTH, 1),
            cfg_row(nnsa_pkg::REG_DST_HEIGHT, 1),
            item_row(1'b0),
            item_row(1'b0),
            typed_row(1'b1, CORNER_LAST),
            cfg_row(nnsa_pkg::REG_SRC_WIDTH, 0),
            cfg_row(nnsa_pkg::REG_DST_WIDTH, 4095),
            cfg_row(nnsa_pkg::REG_DST_HEIGHT, 4095),
            cfg_row(nnsa_pkg::REG_SRC_WIN_X, 0),
            cfg_row(nnsa_pkg::REG_SRC_WIN_Y, 0),
            cfg_row(nnsa_pkg::REG_DST_WIN_X, 0),
            cfg_row(nnsa_pkg::REG_DST_WIN_Y, 0),
            typed_row(1'b1, ORIGIN_PIX),
            item_row(1'b0),
            item_row(1'b0),
            cfg_row(nnsa_pkg::REG_DST_HEIGHT, 0),
            item_row(1'b0),
            item_row(1'b1),
            cfg_row(nnsa_pkg::REG_DST_HEIGHT, 2),
            cfg_row(nnsa_pkg::REG_SRC_WIDTH, 7),
            cfg_row(nnsa_pkg::REG_DST_WIDTH, 4),
            cfg_row(nnsa_pkg::REG_SRC_WIN_X, 1),
            cfg_row(nnsa_pkg::REG_SRC_WIN_Y, 3),
            item_row(1'b0),
            item_row(1'b1),
            item_row(1'b0),
            item_row(1'b0),
            item_row(1'b0),
            item_row(1'b0)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_tab[k].is_cfg)
            begin
                if (k == 0 || !dir_tab[k - 1].is_cfg)
                    quiesce();
                write_reg(dir_tab[k].idx, dir_tab[k].val);
            end
            else
            begin
                issue_tick(dir_tab[k].rs, dir_tab[k].typed, dir_tab[k].want);
            end
        end

        items_done = 0;
        while (items_done < RANDOM_ITEMS)
            run_random_phase();

        quiesce();
        $display("covered %0d ticks, %0d restarts, %0d pixels checked", items_done,
                 restarts_done, pixels_seen);
        $display("%0d row ends and %0d frame ends seen, %0d mismatches", rows_seen,
                 frames_seen, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
